### rtl/core/lavb_pkg.sv
// Shared types and fixed-point helpers for the look-at view basis block.
// Used by lavb_front, lavb_core and the top level, which sizes lavb_fifo by ITEM_W.
package lavb_pkg;

  localparam int unsigned IN_W   = 288;
  localparam int unsigned OUT_W  = 88;
  localparam int unsigned USER_W = 3;
  localparam int unsigned MUL_W  = 34;

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_BACK  = 2'd2;

  // One queued item: eye point, eye minus target, up vector.
  typedef struct packed {
    logic [2:0][31:0] up;
    logic [2:0][32:0] dlt;
    logic [2:0][31:0] eye;
  } item_t;

  localparam int unsigned ITEM_W = $bits(item_t);

  // Shift right by k, rounding half away from zero.
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                              input int unsigned k);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (k - 1))) >> k;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [1:0] nxt3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

endpackage

### rtl/core/lavb_fifo.sv
// Two-word queue between the front and the back of the look-at block.
// Depends on nothing but its width parameter.
module lavb_fifo #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/core/lavb_front.sv
// Input side of the look-at block: takes words and forms eye minus target.
// Depends on lavb_pkg for item_t.
module lavb_front (
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [lavb_pkg::IN_W-1:0]       s_axis_tdata_i,
  input  logic                            full_i,
  output logic                            push_o,
  output lavb_pkg::item_t                 item_o
);
  import lavb_pkg::*;

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item_o.eye[i] = s_axis_tdata_i[32*i +: 32];
      item_o.up[i]  = s_axis_tdata_i[32*(i+6) +: 32];
      item_o.dlt[i] = 33'($signed(s_axis_tdata_i[32*i +: 32]))
                    - 33'($signed(s_axis_tdata_i[32*(i+3) +: 32]));
    end
  end

endmodule

### rtl/core/lavb_core.sv
// Back end of the look-at block: sequencer with one shared multiplier,
// a bit-serial square root and a bit-serial divider. Depends on lavb_pkg.
module lavb_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  lavb_pkg::item_t        item_i,
  output logic                   item_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             out_row_o,
  output logic [2:0][17:0]       out_axis_o,
  output logic [31:0]            out_offset_o,
  output logic                   out_degen_o,
  output logic                   out_last_o
);
  import lavb_pkg::*;

  localparam int unsigned AW  = FRAC_BITS + 2;
  localparam int unsigned QB  = FRAC_BITS + 2;
  localparam int unsigned QCW = $clog2(QB + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ABS  = 4'd1;
  localparam logic [3:0] S_NORM = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_DIVI = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_K    = 4'd7;
  localparam logic [3:0] S_YR   = 4'd8;
  localparam logic [3:0] S_X    = 4'd9;
  localparam logic [3:0] S_OFF  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]             state_q;
  logic signed [31:0]     eye_q [3];
  logic signed [31:0]     up_q  [3];
  logic signed [33:0]     v_q   [3];
  logic [33:0]            mag_q [3];
  logic [2:0]             sgn_q;
  logic signed [AW-1:0]   ax_q  [3][3];
  logic [31:0]            off_q [3];
  logic                   ok_q, pass_q;
  logic [1:0]             j_q, cnt_q, row_q;
  logic signed [63:0]     prod_q, acc_q;
  logic signed [33:0]     k_q;
  logic [63:0]            sq_n_q, sq_r_q, sq_bit_q;
  logic [31:0]            len_q;
  logic [31:0]            dv_rem_q;
  logic [QB-1:0]          dv_n_q, dv_quo_q;
  logic [QCW-1:0]         dv_cnt_q;

  logic signed [33:0]     a_op, b_op;
  logic signed [67:0]     prod_full;
  logic signed [63:0]     acc_sum;
  logic [1:0]             c_idx, c1, c2, pi;
  logic                   hi, lo, allz;
  logic [63:0]            sq_t;
  logic                   sq_ge;
  logic [63:0]            sq_r_d;
  logic [63:0]            dv_nn;
  logic [32:0]            dv_rem2;
  logic                   dv_ge;
  logic [QB-1:0]          dv_q_d;
  logic [1:0]             ax_row;
  logic signed [63:0]     x_rnd, one_fx;

  assign c_idx   = (cnt_q == 2'd3) ? 2'd0 : cnt_q;
  assign c1      = nxt3(j_q);
  assign c2      = nxt3(c1);
  assign pi      = cnt_q - 2'd1;
  assign acc_sum = acc_q + prod_q;

  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (state_q)
      S_SQ: begin
        a_op = $signed(mag_q[c_idx]);
        b_op = $signed(mag_q[c_idx]);
      end
      S_K: begin
        a_op = 34'(up_q[c_idx]);
        b_op = 34'(ax_q[ROW_BACK][c_idx]);
      end
      S_YR: begin
        a_op = 34'(ax_q[ROW_BACK][c_idx]);
        b_op = k_q;
      end
      S_X: begin
        if (cnt_q == 2'd0) begin
          a_op = 34'(ax_q[ROW_UP][c1]);
          b_op = 34'(ax_q[ROW_BACK][c2]);
        end else begin
          a_op = 34'(ax_q[ROW_UP][c2]);
          b_op = -34'(ax_q[ROW_BACK][c1]);
        end
      end
      S_OFF: begin
        a_op = 34'(ax_q[j_q][c_idx]);
        b_op = 34'(eye_q[c_idx]);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod_full = a_op * b_op;

  // Normalization window is [2^29, 2^30).
  assign hi   = |{mag_q[0][33:30], mag_q[1][33:30], mag_q[2][33:30]};
  assign lo   = ~|{mag_q[0][33:29], mag_q[1][33:29], mag_q[2][33:29]};
  assign allz = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);

  assign sq_t   = sq_r_q + sq_bit_q;
  assign sq_ge  = (sq_n_q >= sq_t);
  assign sq_r_d = sq_ge ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);

  assign dv_nn   = (64'(mag_q[j_q]) << FRAC_BITS) + 64'(len_q >> 1);
  assign dv_rem2 = {dv_rem_q, dv_n_q[QB-1]};
  assign dv_ge   = (dv_rem2 >= {1'b0, len_q});
  assign dv_q_d  = {dv_quo_q[QB-2:0], dv_ge};
  assign ax_row  = pass_q ? ROW_UP : ROW_BACK;

  assign x_rnd  = rshr(acc_sum, FRAC_BITS);
  assign one_fx = 64'sd1 <<< FRAC_BITS;

  assign item_pop_o = (state_q == S_IDLE) && item_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= 2'd0;
      cnt_q   <= 2'd0;
      j_q     <= 2'd0;
    end else begin
      prod_q <= prod_full[63:0];
      unique case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            for (int i = 0; i < 3; i++) begin
              eye_q[i] <= $signed(item_i.eye[i]);
              up_q[i]  <= $signed(item_i.up[i]);
              v_q[i]   <= 34'($signed(item_i.dlt[i]));
            end
            pass_q  <= 1'b0;
            ok_q    <= 1'b1;
            state_q <= S_ABS;
          end
        end
        S_ABS: begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= v_q[i][33] ? 34'(-v_q[i]) : 34'(v_q[i]);
            sgn_q[i] <= v_q[i][33];
          end
          state_q <= S_NORM;
        end
        S_NORM: begin
          priority if (allz) begin
            ok_q <= 1'b0;
            for (int r = 0; r < 3; r++) begin
              off_q[r] <= '0;
              for (int i = 0; i < 3; i++) ax_q[r][i] <= '0;
            end
            row_q   <= 2'd0;
            state_q <= S_OUT;
          end else if (hi) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          end else if (lo) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
          end else begin
            cnt_q   <= 2'd0;
            state_q <= S_SQ;
          end
        end
        S_SQ, S_K: begin
          acc_q <= (cnt_q == 2'd0) ? 64'sd0 : acc_sum;
          // the count wraps from three back to zero
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            if (state_q == S_SQ) begin
              sq_n_q   <= 64'(acc_sum);
              sq_r_q   <= '0;
              sq_bit_q <= 64'd1 << 62;
              state_q  <= S_SQRT;
            end else begin
              k_q     <= 34'(x_rnd);
              state_q <= S_YR;
            end
          end
        end
        S_SQRT: begin
          if (sq_ge) sq_n_q <= sq_n_q - sq_t;
          sq_r_q   <= sq_r_d;
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q == 64'd1) begin
            len_q   <= sq_r_d[31:0];
            j_q     <= 2'd0;
            state_q <= S_DIVI;
          end
        end
        S_DIVI: begin
          dv_rem_q <= 32'(dv_nn >> QB);
          dv_n_q   <= dv_nn[QB-1:0];
          dv_quo_q <= '0;
          dv_cnt_q <= '0;
          state_q  <= S_DIV;
        end
        S_DIV: begin
          dv_rem_q <= dv_ge ? 32'(dv_rem2 - {1'b0, len_q}) : dv_rem2[31:0];
          dv_n_q   <= dv_n_q << 1;
          dv_quo_q <= dv_q_d;
          dv_cnt_q <= dv_cnt_q + QCW'(1);
          if (dv_cnt_q == QCW'(QB - 1)) begin
            ax_q[ax_row][j_q] <= sgn_q[j_q] ? -$signed(dv_q_d) : $signed(dv_q_d);
            if (j_q == 2'd2) begin
              j_q     <= 2'd0;
              cnt_q   <= 2'd0;
              state_q <= pass_q ? S_X : S_K;
            end else begin
              j_q     <= j_q + 2'd1;
              state_q <= S_DIVI;
            end
          end
        end
        S_YR: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q != 2'd0) begin
            v_q[pi] <= 34'(up_q[pi]) - 34'(rshr(prod_q, FRAC_BITS));
          end
          if (cnt_q == 2'd3) begin
            pass_q  <= 1'b1;
            state_q <= S_ABS;
          end
        end
        S_X: begin
          acc_q <= (cnt_q == 2'd0) ? 64'sd0 : acc_sum;
          cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
          if (cnt_q == 2'd2) begin
            priority if (x_rnd > one_fx) ax_q[ROW_RIGHT][j_q] <= AW'(one_fx);
            else if (x_rnd < -one_fx) ax_q[ROW_RIGHT][j_q] <= AW'(-one_fx);
            else ax_q[ROW_RIGHT][j_q] <= AW'(x_rnd);
            j_q   <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
            if (j_q == 2'd2) state_q <= S_OFF;
          end
        end
        S_OFF: begin
          acc_q <= (cnt_q == 2'd0) ? 64'sd0 : acc_sum;
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            off_q[j_q] <= sat32(-x_rnd);
            j_q        <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
            if (j_q == 2'd2) begin
              row_q   <= 2'd0;
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            row_q <= (row_q == ROW_BACK) ? 2'd0 : row_q + 2'd1;
            if (row_q == ROW_BACK) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_axis_o[i] = 18'(64'(ax_q[row_q][i]));
    end
  end

  assign out_valid_o  = (state_q == S_OUT);
  assign out_row_o    = row_q;
  assign out_offset_o = off_q[row_q];
  assign out_degen_o  = !ok_q;
  assign out_last_o   = (row_q == ROW_BACK);

endmodule

### rtl/core/look_at_view_basis.sv
// Top level of the look-at view basis block: front, queue and back end.
// Depends on lavb_pkg, lavb_front, lavb_fifo and lavb_core.
//
//  port group  dir  tdata (low bit up)                        tuser / tlast
//  s_axis      in   eye_x..z, target_x..z, up_x..z (32 each)   -
//  m_axis      out  axis_x, axis_y, axis_z (18), row_offset    row_index, degenerate / last_row
//
// Each word yields three rows, right, up and back. The back end takes a word
// through two normalizations, each with a one-bit-per-cycle scaling loop of up
// to 29 steps, a 32-step square root and three bit-serial divisions of
// FRAC_BITS+2 quotient bits each, plus products on one multiplier and three
// output rows. A zero back axis goes to the rows at the first normalization,
// a zero up axis at the second. A low m_axis_tready_i holds the current row.
// The two-word queue takes input while rows wait on m_axis, until it is full.
// Reset is asynchronous, active low, and empties the queue and the sequencer.
module look_at_view_basis #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  logic [lavb_pkg::IN_W-1:0]     s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // axis_x, axis_y, axis_z, row_offset, two zero bits
  output logic [lavb_pkg::OUT_W-1:0]    m_axis_tdata_o,
  // row_index, degenerate
  output logic [lavb_pkg::USER_W-1:0]   m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);
  import lavb_pkg::*;

  item_t            push_item, pop_item;
  logic             push, full, q_valid, pop;
  logic [1:0]       row;
  logic [2:0][17:0] axis;
  logic [31:0]      offset;
  logic             degen;

  lavb_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .full_i          (full),
    .push_o          (push),
    .item_o          (push_item)
  );

  lavb_fifo #(.W(ITEM_W)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rdata_o (pop_item)
  );

  lavb_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (pop_item),
    .item_pop_o   (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_row_o    (row),
    .out_axis_o   (axis),
    .out_offset_o (offset),
    .out_degen_o  (degen),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, offset, axis[2], axis[1], axis[0]};
  assign m_axis_tuser_o = {degen, row};

`ifndef ASSERT_OFF
  a_last_on_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o[1:0] == ROW_BACK)))
    else $error("tlast does not match the back row");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[2]) |-> (m_axis_tdata_o == '0))
    else $error("degenerate row carries nonzero data");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && (m_axis_tuser_o[1:0] == $past(m_axis_tuser_o[1:0]) + 2'd1)))
    else $error("rows not delivered in order");
`endif

endmodule

### tb/look_at_view_basis_tb.sv
// Testbench for look_at_view_basis: drives eye/target/up words, predicts the three view rows.
// Depends on lavb_pkg and look_at_view_basis; checks every row field by field.
`timescale 1ns / 1ps

module look_at_view_basis_tb;
  import lavb_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam longint ONE_FX = longint'(1) << FRAC;

  typedef longint vec3_t [3];

  typedef struct packed {
    logic [1:0]  row_index;
    logic [17:0] axis_x;
    logic [17:0] axis_y;
    logic [17:0] axis_z;
    logic [31:0] row_offset;
    logic        degenerate;
    logic        last_row;
  } view_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [IN_W-1:0] s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OUT_W-1:0] m_data;
  logic [USER_W-1:0] m_user;
  logic m_last;

  view_row_t rows_due[$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned rows_seen = 0;
  int unsigned degen_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  always #5 clk_i = ~clk_i;

  look_at_view_basis #(.FRAC_BITS(FRAC)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  function automatic longint round_shift(longint v, int unsigned k);
    longint unsigned mag;
    mag = (v < 0) ? longint'(0) - v : v;
    mag = (mag + (longint'(1) << (k - 1))) >> k;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit normalize(input vec3_t a, output vec3_t u);
    longint unsigned m [3];
    longint unsigned mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (a[i] < 0) ? longint'(0) - a[i] : a[i];
      if (m[i] > mx) mx = m[i];
    end
    u[0] = 0; u[1] = 0; u[2] = 0;
    if (mx == 0) return 1'b0;
    while (mx >= (longint'(1) << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (longint'(1) << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC) + (len >> 1)) / len;
      u[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint dot_fx(vec3_t a, vec3_t b);
    return round_shift(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], FRAC);
  endfunction

  function automatic longint clamp_one(longint v);
    return (v > ONE_FX) ? ONE_FX : ((v < -ONE_FX) ? -ONE_FX : v);
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > longint'(32'sh7fffffff)) return 32'h7fff_ffff;
    if (v < -longint'(64'h80000000)) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Predict the right, up and back rows for one word and queue them.
  task automatic predict_view_rows(input logic [31:0] f [9]);
    vec3_t eye, up, dv, yr, bx, ux, rx, k3;
    longint k;
    bit ok;
    view_row_t row;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(f[i]));
      dv[i] = eye[i] - longint'($signed(f[3 + i]));
      up[i] = longint'($signed(f[6 + i]));
    end
    ok = normalize(dv, bx);
    ux = '{0, 0, 0};
    if (ok) begin
      k = dot_fx(up, bx);
      for (int i = 0; i < 3; i++) yr[i] = up[i] - round_shift(bx[i] * k, FRAC);
      ok = normalize(yr, ux);
    end
    if (ok) begin
      rx[0] = clamp_one(round_shift(ux[1] * bx[2] - ux[2] * bx[1], FRAC));
      rx[1] = clamp_one(round_shift(ux[2] * bx[0] - ux[0] * bx[2], FRAC));
      rx[2] = clamp_one(round_shift(ux[0] * bx[1] - ux[1] * bx[0], FRAC));
    end else begin
      rx = '{0, 0, 0}; ux = '{0, 0, 0}; bx = '{0, 0, 0};
    end
    for (int r = 0; r < 3; r++) begin
      if (r == 0) begin
        k3 = rx;
        row.row_index = ROW_RIGHT;
      end else if (r == 1) begin
        k3 = ux;
        row.row_index = ROW_UP;
      end else begin
        k3 = bx;
        row.row_index = ROW_BACK;
      end
      row.axis_x = k3[0][17:0];
      row.axis_y = k3[1][17:0];
      row.axis_z = k3[2][17:0];
      row.row_offset = ok ? clip32(-dot_fx(k3, eye)) : 32'd0;
      row.degenerate = !ok;
      row.last_row = (r == 2);
      rows_due.push_back(row);
    end
  endtask

  task automatic send_word(input logic [31:0] f [9]);
    logic [IN_W-1:0] packed_word;
    for (int i = 0; i < 9; i++) packed_word[32 * i +: 32] = f[i];
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= packed_word;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    predict_view_rows(f);
    words_sent++;
  endtask

  task automatic wait_rows_drained();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (rows_due.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    view_row_t want;
    view_row_t got;
    if (rst_ni && m_valid && m_ready) begin
      got.axis_x = m_data[17:0];
      got.axis_y = m_data[35:18];
      got.axis_z = m_data[53:36];
      got.row_offset = m_data[85:54];
      got.row_index = m_user[1:0];
      got.degenerate = m_user[2];
      got.last_row = m_last;
      rows_seen++;
      if (got.degenerate) degen_seen++;
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected row idx=%0d off=%h", $time, got.row_index, got.row_offset);
        errors++;
      end else begin
        want = rows_due.pop_front();
        if (got != want) begin
          $display("%0t: row mismatch expected idx=%0d ax=%h ay=%h az=%h off=%h dg=%b last=%b",
                   $time, want.row_index, want.axis_x, want.axis_y, want.axis_z,
                   want.row_offset, want.degenerate, want.last_row);
          $display("%0t:              actual idx=%0d ax=%h ay=%h az=%h off=%h dg=%b last=%b",
                   $time, got.row_index, got.axis_x, got.axis_y, got.axis_z,
                   got.row_offset, got.degenerate, got.last_row);
          errors++;
        end
      end
    end
  end

  task automatic send_nine(input int ex, ey, ez, tx, ty, tz, ux, uy, uz);
    logic [31:0] f [9];
    f = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    send_word(f);
  endtask

  task automatic test_directed();
    int mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    send_nine(0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0);
    send_nine(3 << 16, -2 << 16, 7 << 16, -1 << 16, 4 << 16, 2 << 16, 0, 1 << 16, 0);
    // eye on target: zero back axis
    send_nine(12345, -999, 77, 12345, -999, 77, 0, 1 << 16, 0);
    // up along the view direction: no orthogonal part
    send_nine(0, 0, 5 << 16, 0, 0, 0, 0, 0, 3 << 16);
    send_nine(1 << 16, 2 << 16, 3 << 16, 0, 0, 0, 0, 0, 0);
    send_nine(mx, mx, mx, mn, mn, mn, mx, mn, mx);
    send_nine(mn, mn, mn, mx, mx, mx, mn, mx, mn);
    send_nine(mx, mx, mx, mx - 65536, mx, mx, 0, mx, 0);
    send_nine(mn, mx, mn, mn, mx, mn + 1, mx, 0, mn);
    // huge eye with a short direction drives offsets into saturation
    send_nine(mx, mn, mx, mx - 3, mn + 5, mx - 7, 1, -1, 1);
    send_nine(mn, mn, mx, mn + 1, mn, mx, 0, 0, 0);
    send_nine(-1, -1, -1, 0, 0, 0, -1, 1, -1);
    send_nine(0, 0, 0, -1 << 16, 0, 0, 0, -1 << 16, 1);
    send_nine(1, 0, 0, 0, 0, 0, 0, 1, 0);
    wait_rows_drained();
  endtask

  function automatic int small_val();
    return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  task automatic test_random(input int unsigned n, input int unsigned idle, input int unsigned stall);
    logic [31:0] f [9];
    int unsigned pick;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) begin
      pick = $urandom_range(99);
      for (int i = 0; i < 9; i++) f[i] = (pick < 35) ? $urandom() : small_val();
      if (pick >= 85 && pick < 93) begin
        for (int i = 0; i < 3; i++) f[3 + i] = f[i];
      end else if (pick >= 93) begin
        // up parallel to the view direction
        for (int i = 0; i < 3; i++) f[6 + i] = f[i] - f[3 + i];
      end
      send_word(f);
    end
    wait_rows_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(100, 0, 0);
    test_random(100, 82, 0);
    test_random(100, 0, 82);
    test_random(100, 37, 37);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (400) @(posedge clk_i);
    $display("Sent %0d words, checked %0d rows, %0d of them degenerate,", words_sent,
             rows_seen, degen_seen);
    $display("over idle-free, sender-idle, receiver-stall and mixed phases.");
    if (errors == 0 && rows_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
rtl/core/lavb_pkg.sv
rtl/core/lavb_fifo.sv
rtl/core/lavb_front.sv
rtl/core/lavb_core.sv
rtl/core/look_at_view_basis.sv
tb/look_at_view_basis_tb.sv
